// ===== hdl/object_id_pool_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the object id pool allocator
// Clocked implication checks used by the RTL file oidp_core.
// ----------------------------------------------------------------------------
`ifndef OBJECT_ID_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define OBJECT_ID_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define OIDP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define OIDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/oidp_pkg.sv =====
// ----------------------------------------------------------------------------
// oidp_pkg
// Shared sizes, codes and types of the object id pool allocator.
// ----------------------------------------------------------------------------
package oidp_pkg;

  localparam int POOL_SIZE = 64;
  localparam int ID_W      = $clog2(POOL_SIZE);
  localparam int COUNT_W   = $clog2(POOL_SIZE + 1);
  localparam int ACT_W     = 2;
  localparam int ST_W      = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_TRY   = 2'd1,
    ACT_FREE  = 2'd2
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK            = 2'd0,
    ST_NONE_FREE     = 2'd1,
    ST_NOT_ALLOCATED = 2'd2,
    ST_EXHAUSTED     = 2'd3
  } status_t;

  // Free queue RAM control, one write port and one read port.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    logic [ID_W-1:0] wdata;
    logic [ID_W-1:0] raddr;
  } ram_ctl_t;

  // Circular pointer increment over POOL_SIZE entries.
  function automatic logic [ID_W-1:0] ptr_inc(input logic [ID_W-1:0] ptr);
    logic [ID_W-1:0] res;
    if (ptr == ID_W'(POOL_SIZE - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== hdl/object_id_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// object_id_pool_allocator_unit
// Object id pool: allocate, try-allocate and deallocate with FIFO reuse.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | word fields
//   --------+----------------------+------------------------
//   request | req_valid/req_stall  | action, release_id
//   result  | rsp_valid/rsp_stall  | granted_id, status
//
// One request word per cycle while rsp_stall stays low; each word gives exactly one result.
// A word passes the input register, then decode/state update into the
// result register. The free queue RAM read port is kept one step ahead of
// the head pointer, which is what lets back-to-back pops run at full rate.
// Reset clears counters, pointers and the in-use bitmap; queue
// RAM contents are not cleared (only written entries are read).
// A stalled result holds the pipe: req_stall rises only when both registers
// are full and rsp_stall is high.
//
module object_id_pool_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [oidp_pkg::ACT_W-1:0]   action,
  input  logic [oidp_pkg::ID_W-1:0]    release_id,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [oidp_pkg::ID_W-1:0]    granted_id,
  output logic [oidp_pkg::ST_W-1:0]    status
);
  import oidp_pkg::*;

  // Input register
  logic              in_full;
  logic [ACT_W-1:0]  in_action;
  logic [ID_W-1:0]   in_rel;

  // Decode results
  logic [ID_W-1:0]   res_id;
  status_t           res_status;

  // Result register
  logic [ID_W-1:0]   out_id;
  status_t           out_status;

  logic              advance;

  // Work moves on whenever the result register is free or being drained.
  assign advance   = in_full && (!rsp_valid || !rsp_stall);
  assign req_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!req_stall) begin
      in_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_action <= action;
      in_rel    <= release_id;
    end
  end

  oidp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .req_action (in_action),
    .req_rel    (in_rel),
    .res_id     (res_id),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_id     <= res_id;
      out_status <= res_status;
    end
  end

  assign granted_id = out_id;
  assign status     = out_status;

endmodule

// ===== hdl/oidp_fifo_ram.sv =====
// ----------------------------------------------------------------------------
// oidp_fifo_ram
// Free queue storage: one write, one registered read with write bypass.
// ----------------------------------------------------------------------------
module oidp_fifo_ram (
  input  logic                         clk,
  input  oidp_pkg::ram_ctl_t           ctl,
  output logic [oidp_pkg::ID_W-1:0]    rd_data
);
  import oidp_pkg::*;

  logic [ID_W-1:0] mem [POOL_SIZE];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  // New data wins when the same entry is written and read in one cycle.
  always_ff @(posedge clk) begin
    if (ctl.we && (ctl.waddr == ctl.raddr)) begin
      rd_data <= ctl.wdata;
    end else begin
      rd_data <= mem[ctl.raddr];
    end
  end

endmodule

// ===== hdl/oidp_core.sv =====
// ----------------------------------------------------------------------------
// oidp_core
// Pool state, request decode and free queue pointers.
// ----------------------------------------------------------------------------
`include "object_id_pool_allocator_unit_assert.svh"

module oidp_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [oidp_pkg::ACT_W-1:0]   req_action,
  input  logic [oidp_pkg::ID_W-1:0]    req_rel,
  output logic [oidp_pkg::ID_W-1:0]    res_id,
  output oidp_pkg::status_t            res_status
);
  import oidp_pkg::*;

  logic [COUNT_W-1:0]   fresh_count;
  logic [POOL_SIZE-1:0] in_use_map;
  logic [ID_W-1:0]      queue_head;
  logic [ID_W-1:0]      queue_tail;
  logic [COUNT_W-1:0]   queue_count;
  logic [ID_W-1:0]      queue_head_next;
  logic [ID_W-1:0]      head_data;
  ram_ctl_t             ram_ctl;

  logic            pop;
  logic            push;
  logic            fresh;
  logic            rel_ok;

  assign rel_ok = ({1'b0, req_rel} < COUNT_W'(POOL_SIZE)) && in_use_map[req_rel];

  always_comb begin
    res_id     = '0;
    res_status = ST_OK;
    pop        = 1'b0;
    push       = 1'b0;
    fresh      = 1'b0;
    case (action_t'(req_action))
      ACT_ALLOC, ACT_TRY: begin
        if (queue_count != '0) begin
          pop    = 1'b1;
          res_id = head_data;
        end else if (action_t'(req_action) == ACT_TRY) begin
          res_status = ST_NONE_FREE;
        end else if (fresh_count < COUNT_W'(POOL_SIZE)) begin
          fresh  = 1'b1;
          res_id = fresh_count[ID_W-1:0];
        end else begin
          res_status = ST_EXHAUSTED;
        end
      end
      ACT_FREE: begin
        if (rel_ok) begin
          push = 1'b1;
        end else begin
          res_status = ST_NOT_ALLOCATED;
        end
      end
      default: ;
    endcase
  end

  // Read address follows the head after this cycle, so head_data is always
  // the entry at queue_head.
  assign queue_head_next = (advance && pop) ? ptr_inc(queue_head) : queue_head;

  always_comb begin
    ram_ctl.we    = advance && push;
    ram_ctl.waddr = queue_tail;
    ram_ctl.wdata = req_rel;
    ram_ctl.raddr = queue_head_next;
  end

  oidp_fifo_ram u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .rd_data (head_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_count <= '0;
      in_use_map  <= '0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
    end else if (advance) begin
      queue_head <= queue_head_next;
      if (pop) begin
        in_use_map[head_data] <= 1'b1;
        queue_count           <= queue_count - 1'b1;
      end
      if (fresh) begin
        in_use_map[fresh_count[ID_W-1:0]] <= 1'b1;
        fresh_count                       <= fresh_count + 1'b1;
      end
      if (push) begin
        in_use_map[req_rel] <= 1'b0;
        queue_tail          <= ptr_inc(queue_tail);
        queue_count         <= queue_count + 1'b1;
      end
    end
  end

  `OIDP_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, queue_count <= COUNT_W'(POOL_SIZE), "free queue over capacity")
  `OIDP_ASSERT_NOW(a_id_balance, clk, rst, 1'b1, (COUNT_W'($countones(in_use_map)) + queue_count) == fresh_count, "in use plus free does not match created ids")
  `OIDP_ASSERT_NOW(a_pop_not_in_use, clk, rst, advance && pop, !in_use_map[head_data], "queue head id already in use")
  `OIDP_ASSERT_NEXT(a_free_clears, clk, rst, advance && push, !in_use_map[$past(req_rel)], "released id still marked in use")

endmodule

// ===== tb/oidp_grant_checker.sv =====
// ----------------------------------------------------------------------------
// oidp_grant_checker
// Watches both channels of the id pool, predicts each result word from the
// accepted request words and compares them field by field.
// ----------------------------------------------------------------------------
module oidp_grant_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [oidp_pkg::ACT_W-1:0]  action,
  input  logic [oidp_pkg::ID_W-1:0]   release_id,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic [oidp_pkg::ID_W-1:0]   granted_id,
  input  logic [oidp_pkg::ST_W-1:0]   status,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count
);
  import oidp_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         st;
  } grant_t;

  // pool shadow
  int              created;
  logic            held [POOL_SIZE];
  logic [ID_W-1:0] released_ids [$];

  grant_t expected_grants [$];
  int     fails;
  int     results;

  function automatic grant_t predict_grant(input logic [ACT_W-1:0] act,
                                           input logic [ID_W-1:0]  rel);
    grant_t g;
    g.id = '0;
    g.st = ST_OK;
    case (act)
      ACT_ALLOC, ACT_TRY: begin
        if (released_ids.size() > 0) begin
          g.id = released_ids.pop_front();
          held[g.id] = 1'b1;
        end else if (act == ACT_TRY) begin
          g.st = ST_NONE_FREE;
        end else if (created < POOL_SIZE) begin
          g.id = ID_W'(created);
          created++;
          held[g.id] = 1'b1;
        end else begin
          g.st = ST_EXHAUSTED;
        end
      end
      ACT_FREE: begin
        if (int'(rel) < POOL_SIZE && held[rel]) begin
          held[rel] = 1'b0;
          released_ids.push_back(rel);
        end else begin
          g.st = ST_NOT_ALLOCATED;
        end
      end
      default: ; // unused code: no effect, zero result
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      created = 0;
      for (int i = 0; i < POOL_SIZE; i++) held[i] = 1'b0;
      released_ids.delete();
      expected_grants.delete();
    end else begin
      // result first: it is always older than a request taken this edge
      if (rsp_valid && !rsp_stall) begin
        results++;
        if (expected_grants.size() == 0) begin
          $error("unexpected result word: granted_id %0d status %0d", granted_id, status);
          fails++;
        end else begin
          want = expected_grants.pop_front();
          if (granted_id !== want.id) begin
            $error("granted_id mismatch: expected %0d, actual %0d", want.id, granted_id);
            fails++;
          end
          if (status !== want.st) begin
            $error("status mismatch: expected %0d, actual %0d", want.st, status);
            fails++;
          end
        end
      end
      if (req_valid && !req_stall)
        expected_grants.push_back(predict_grant(action, release_id));
    end
    fail_count   <= fails;
    pending      <= expected_grants.size();
    result_count <= results;
  end

endmodule

// ===== tb/tb_object_id_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_object_id_pool_allocator_unit
// Drives request words into the id pool and stalls the result channel at
// random; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_object_id_pool_allocator_unit;
  import oidp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;  // no enum member, must be a no-op
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 240;
  localparam int HOLD_CYCLES = 150;     // long receiver hold-off
  localparam int TAIL_CYCLES = 6;       // margin past the input and result registers
  localparam int CYCLE_LIMIT = 200000;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             req_valid  = 1'b0;
  logic             req_stall;
  logic [ACT_W-1:0] action     = '0;
  logic [ID_W-1:0]  release_id = '0;
  logic             rsp_valid;
  logic             rsp_stall  = 1'b0;
  logic [ID_W-1:0]  granted_id;
  logic [ST_W-1:0]  status;

  int fail_count;
  int pending;
  int result_count;

  // shared between stimulus and receiver processes
  bit calm         = 1'b0;   // no idling on either side while set
  int hold_request = 0;      // stimulus asks, receiver counts it down
  int hold_left    = 0;
  int words_sent   = 0;
  int cycles       = 0;

  always #6 clk = ~clk;

  object_id_pool_allocator_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .release_id (release_id),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .granted_id (granted_id),
    .status     (status)
  );

  oidp_grant_checker u_grant_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .release_id   (release_id),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted_id   (granted_id),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // Watchdog: also catches result words that never show up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random single-cycle stalls, or a long counted hold-off on request.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  // One request word: optional idle cycle, then hold it until accepted.
  // Called at a rising edge, returns at the edge where the word was taken.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] rel);
    if (!calm && $urandom_range(99) < 7) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    action     <= act;
    release_id <= rel;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
  endtask

  // Stop offering and wait for every outstanding result word.
  // Checker counters are registered at the edge, so poll them only after it.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int wa, wt, wf, r;
    logic [ID_W-1:0] rid;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty pool, bad releases, unused code, FIFO reuse order
    send_word(ACT_TRY, '0);            // nothing released yet: none free
    send_word(ACT_FREE, '0);           // never created
    send_word(ACT_FREE, '1);           // top id, never created
    send_word(ACT_UNUSED, '1);         // ignored
    send_word(ACT_ALLOC, '1);          // fresh 0
    send_word(ACT_ALLOC, '0);          // fresh 1
    send_word(ACT_ALLOC, '0);          // fresh 2
    send_word(ACT_FREE, ID_W'(1));
    send_word(ACT_FREE, ID_W'(0));
    send_word(ACT_FREE, ID_W'(1));     // double release
    send_word(ACT_TRY, '1);            // oldest released first: 1
    send_word(ACT_ALLOC, '0);          // then 0
    send_word(ACT_TRY, '0);            // queue empty again
    send_word(ACT_UNUSED, '0);

    // fill every fresh id, then run into exhaustion
    repeat (POOL_SIZE - 3) send_word(ACT_ALLOC, ID_W'($urandom));
    send_word(ACT_ALLOC, '0);          // exhausted
    send_word(ACT_TRY, '0);            // none free
    send_word(ACT_FREE, '1);
    send_word(ACT_FREE, '0);
    send_word(ACT_ALLOC, '0);          // reuse 63
    send_word(ACT_TRY, '0);            // reuse 0
    send_word(ACT_ALLOC, '0);          // exhausted again
    send_word(ACT_FREE, ID_W'(42));
    send_word(ACT_FREE, ID_W'(42));    // double release
    send_word(ACT_TRY, '0);            // reuse 42

    // --- random phases: even ones keep the pool near full (exhaustion and
    // none-free), odd ones release heavily so reuse order gets mixed up.
    // Uniform release ids hit held ids in proportion to pool occupancy.
    for (int p = 0; p < PHASES; p++) begin
      if (p % 2 == 0) begin
        wa = 55; wt = 15; wf = 26;
      end else begin
        wa = 12; wt = 10; wf = 74;
      end
      calm = (p == 2);
      if (p == 3) hold_request = HOLD_CYCLES;  // pipe fills, req_stall rises
      if (p == 5) drain_results();             // sender waits for an empty pipe
      for (int i = 0; i < PHASE_WORDS; i++) begin
        r   = $urandom_range(99);
        rid = ID_W'($urandom);
        if (r < wa)                send_word(ACT_ALLOC, rid);
        else if (r < wa + wt)      send_word(ACT_TRY, rid);
        else if (r < wa + wt + wf) send_word(ACT_FREE, rid);
        else                       send_word(ACT_UNUSED, rid);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d request words: empty pool, fill to exhaustion, FIFO reuse,",
             words_sent);
    $display("  %0d random phases and a %0d-cycle hold-off; %0d result words compared",
             PHASES, HOLD_CYCLES, result_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/oidp_pkg.sv
hdl/oidp_fifo_ram.sv
hdl/oidp_core.sv
hdl/object_id_pool_allocator_unit.sv
tb/oidp_grant_checker.sv
tb/tb_object_id_pool_allocator_unit.sv
